### rtl/b64enc_pkg.sv
package b64enc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CharW     = 7;
  localparam int unsigned SextetW   = 6;
  localparam int unsigned CarryW    = 4;
  localparam int unsigned MaxChars  = 4;
  localparam int unsigned SlotW     = 2;   // index of a char inside one entry
  localparam int unsigned CountW    = 3;   // 1..MaxChars
  localparam int unsigned FifoDepthDef = 2;

  // APB side
  localparam int unsigned PDataW    = 32;
  localparam int unsigned PAddrW    = 3;
  localparam int unsigned RegIdxLsb = 2;

  typedef enum logic [PAddrW-RegIdxLsb-1:0] {
    RegPadEnable = 1'b0
  } reg_idx_e;

  localparam logic [CharW-1:0] PadChar = CharW'(8'h3d);   // '='

  // Entry handed from the front to the back: up to four finished chars.
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CountW-1:0]              count;
    logic                           last;
  } b64enc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64enc_fifo_stat_t;

  // Map one sextet onto the A-Z a-z 0-9 + / alphabet.
  function automatic logic [CharW-1:0] b64_char(input logic [SextetW-1:0] v);
    logic [CharW-1:0] r;
    if (v < SextetW'(26)) begin
      r = CharW'(8'h41) + CharW'(v);
    end else if (v < SextetW'(52)) begin
      r = CharW'(8'h61) + CharW'(v - SextetW'(26));
    end else if (v < SextetW'(62)) begin
      r = CharW'(8'h30) + CharW'(v - SextetW'(52));
    end else if (v == SextetW'(62)) begin
      r = CharW'(8'h2b);
    end else begin
      r = CharW'(8'h2f);
    end
    return r;
  endfunction

endpackage

### rtl/b64enc_byte_if.sv
interface b64enc_byte_if;
  logic                          valid;
  logic                          ready;
  logic [b64enc_pkg::ByteW-1:0]  in_byte;
  logic                          last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

### rtl/b64enc_char_if.sv
interface b64enc_char_if;
  logic                          valid;
  logic                          ready;
  logic [b64enc_pkg::CharW-1:0]  out_char;
  logic                          last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

### rtl/b64enc_front.sv
module b64enc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pad_enable_i,
  input  logic                       valid_i,
  input  logic [b64enc_pkg::ByteW-1:0] in_byte_i,
  input  logic                       last_byte_i,
  input  logic                       accept_i,
  output b64enc_pkg::b64enc_entry_t  entry_o
);
  import b64enc_pkg::*;

  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseSecond = 2'd1,
    PhaseThird  = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CarryW-1:0] carry_q, carry_d;
  b64enc_entry_t     entry;

  always_comb begin
    entry.chars = '{default: PadChar};
    entry.count = CountW'(1);
    entry.last  = last_byte_i;
    phase_d     = phase_q;
    carry_d     = carry_q;
    case (phase_q)
      PhaseSecond: begin
        entry.chars[0] = b64_char({carry_q[1:0], in_byte_i[7:4]});
        carry_d        = in_byte_i[3:0];
        phase_d        = PhaseThird;
        if (last_byte_i) begin
          entry.chars[1] = b64_char({in_byte_i[3:0], 2'b00});
          entry.count    = pad_enable_i ? CountW'(3) : CountW'(2);
        end
      end
      PhaseThird: begin
        entry.chars[0] = b64_char({carry_q, in_byte_i[7:6]});
        entry.chars[1] = b64_char(in_byte_i[5:0]);
        entry.count    = CountW'(2);
        carry_d        = '0;
        phase_d        = PhaseFirst;
      end
      default: begin
        // a stray phase code falls in here too and starts a new group
        entry.chars[0] = b64_char(in_byte_i[7:2]);
        carry_d        = {2'b00, in_byte_i[1:0]};
        phase_d        = PhaseSecond;
        if (last_byte_i) begin
          entry.chars[1] = b64_char({in_byte_i[1:0], 4'b0000});
          entry.count    = pad_enable_i ? CountW'(4) : CountW'(2);
        end
      end
    endcase
    if (last_byte_i) begin
      phase_d = PhaseFirst;
      carry_d = '0;
    end
  end

  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseFirst;
      carry_q <= '0;
    end else if (valid_i && accept_i) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

### rtl/b64enc_fifo.sv
module b64enc_fifo #(
  parameter int unsigned Depth = b64enc_pkg::FifoDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  b64enc_pkg::b64enc_entry_t     push_data_i,
  input  logic                          pop_i,
  output b64enc_pkg::b64enc_entry_t     head_o,
  output b64enc_pkg::b64enc_fifo_stat_t stat_o
);
  import b64enc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  b64enc_entry_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/b64enc_back.sv
module b64enc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  b64enc_pkg::b64enc_entry_t     head_i,
  input  b64enc_pkg::b64enc_fifo_stat_t stat_i,
  output logic                          pop_o,
  output logic                          valid_o,
  output logic [b64enc_pkg::CharW-1:0]  out_char_o,
  output logic                          last_char_o,
  input  logic                          ready_i
);
  import b64enc_pkg::*;

  logic [SlotW-1:0] slot_q;
  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             load, take, final_slot;

  assign load       = !valid_q || ready_i;
  assign take       = load && !stat_i.empty;
  assign final_slot = ({1'b0, slot_q} == head_i.count - CountW'(1));
  assign pop_o      = take && final_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= !stat_i.empty;
      end
      if (take) begin
        slot_q <= final_slot ? '0 : slot_q + SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      char_q <= head_i.chars[slot_q];
      last_q <= head_i.last && final_slot;
    end
  end

  assign valid_o     = valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

endmodule

### rtl/base64_stream_encoder_unit.sv
// Channel   | Dir | Beat                        | Handshake
// ----------+-----+-----------------------------+-------------------------------
// in_if     | in  | in_byte[7:0], last_byte     | valid/ready, taken on both high
// out_if    | out | out_char[6:0], last_char    | valid/ready, taken on both high
// APB       | in  | pwdata[0] = pad_enable      | setup + access, pready tied high
//
// A byte is taken whenever the entry queue has room; the front turns it
// into one to four characters at once. The back drains the queue through
// the output register at one character per cycle while out_if.ready is high;
// a byte yields one to four characters (four thirds on average in a message).
// Reset clears the group phase, the queue and the output register and sets
// pad_enable; no clearing pass. A stalled output holds its beat while the
// front keeps filling the queue; a full queue drops in_if.ready.
module base64_stream_encoder_unit #(
  parameter int unsigned FifoDepth = b64enc_pkg::FifoDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  b64enc_byte_if.sink                      in_if,
  b64enc_char_if.source                    out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [b64enc_pkg::PAddrW-1:0]    paddr,
  input  logic [b64enc_pkg::PDataW-1:0]    pwdata,
  output logic [b64enc_pkg::PDataW-1:0]    prdata,
  output logic                             pready
);
  import b64enc_pkg::*;

  logic              pad_enable_q;
  logic              cfg_wr;
  reg_idx_e          reg_idx;
  b64enc_entry_t     entry, head;
  b64enc_fifo_stat_t fifo_stat;
  logic              pop;

  // Configuration: one register, written in the access phase.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PAddrW-1:RegIdxLsb]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_enable_q <= 1'b1;
    end else if (cfg_wr && (reg_idx == RegPadEnable)) begin
      pad_enable_q <= pwdata[0];
    end
  end

  always_comb begin
    case (reg_idx)
      RegPadEnable: prdata = {{(PDataW-1){1'b0}}, pad_enable_q};
      default:      prdata = '0;
    endcase
  end

  // Accept a byte whenever the queue has a free entry.
  assign in_if.ready = !fifo_stat.full;

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pad_enable_i (pad_enable_q),
    .valid_i      (in_if.valid),
    .in_byte_i    (in_if.in_byte),
    .last_byte_i  (in_if.last_byte),
    .accept_i     (in_if.ready),
    .entry_o      (entry)
  );

  b64enc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_if.valid),
    .push_data_i (entry),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  // Drain one character per cycle into the output register while out_if.ready is high.
  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (fifo_stat),
    .pop_o       (pop),
    .valid_o     (out_if.valid),
    .out_char_o  (out_if.out_char),
    .last_char_o (out_if.last_char),
    .ready_i     (out_if.ready)
  );

endmodule

### tb/tb_base64_stream_encoder_unit.sv
`timescale 1ns / 1ps

module tb_base64_stream_encoder_unit;
  import b64enc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ItemsPerPhase = 125;
  localparam int unsigned RandPhases    = 4;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned SpareRegIdx   = 1;   // no register lives here
  localparam logic [PAddrW-1:0] PadAddr   = PAddrW'(RegPadEnable) << RegIdxLsb;
  localparam logic [PAddrW-1:0] SpareAddr = PAddrW'(SpareRegIdx) << RegIdxLsb;

  // Position inside the current 3-byte group.
  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseSecond = 2'd1,
    PhaseThird  = 2'd2
  } group_phase_e;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             lst;
  } char_beat_t;

  // One directed beat: want is the literal encoding, or empty to use the predictor.
  typedef struct {
    logic [ByteW-1:0] b;
    bit               last;
    bit               pad;
    string            want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [PAddrW-1:0] paddr   = '0;
  logic [PDataW-1:0] pwdata  = '0;
  logic [PDataW-1:0] prdata;
  logic              pready;

  b64enc_byte_if byte_bus ();
  b64enc_char_if char_bus ();

  base64_stream_encoder_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (byte_bus.sink),
    .out_if  (char_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  string glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Predictor state and configuration shadow.
  group_phase_e     grp_phase;
  logic [CarryW-1:0] carry;
  bit               pad_model;

  char_beat_t chars_due[$];    // characters still owed by the block, oldest first

  int unsigned err_cnt      = 0;
  int unsigned bytes_sent   = 0;
  int unsigned chars_seen   = 0;
  int unsigned msgs_sent    = 0;
  int unsigned pad_writes   = 0;
  int unsigned stall_cycles = 0;
  bit          idle_on      = 1'b1;
  bit          hold_req     = 1'b0;

  stim_row_t dir_rows[$] = '{
    '{8'h00, 1'b1, 1'b1, "AA=="},
    '{8'hFF, 1'b1, 1'b1, "/w=="},
    '{8'hFF, 1'b0, 1'b1, "/"},
    '{8'hFF, 1'b1, 1'b1, "/8="},
    '{8'h4D, 1'b0, 1'b1, "T"},
    '{8'h61, 1'b0, 1'b1, "W"},
    '{8'h6E, 1'b1, 1'b1, "Fu"},
    '{8'h00, 1'b0, 1'b1, "A"},
    '{8'h00, 1'b0, 1'b1, "A"},
    '{8'h00, 1'b1, 1'b1, "AA"},
    '{8'hFF, 1'b0, 1'b1, "/"},
    '{8'hFF, 1'b0, 1'b1, "/"},
    '{8'hFF, 1'b1, 1'b1, "//"},
    '{8'h00, 1'b1, 1'b0, "AA"},
    '{8'hFF, 1'b0, 1'b0, "/"},
    '{8'hFF, 1'b1, 1'b0, "/8"},
    '{8'hFB, 1'b0, 1'b0, ""},
    '{8'hFF, 1'b0, 1'b0, ""},
    '{8'hBF, 1'b0, 1'b0, ""},
    '{8'h3E, 1'b0, 1'b0, ""},
    '{8'hA5, 1'b0, 1'b0, ""},
    '{8'h5A, 1'b1, 1'b0, ""},
    '{8'h80, 1'b0, 1'b1, ""},
    '{8'h01, 1'b1, 1'b1, ""}
  };

  function automatic void note_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic logic [CharW-1:0] glyph(logic [SextetW-1:0] s);
    return CharW'(glyphs[s]);
  endfunction

  // Advance the encoder shadow by one byte; queue its characters when keep is set.
  function automatic void encode_byte(logic [ByteW-1:0] b, bit last, bit keep);
    char_beat_t out[$];
    case (grp_phase)
      PhaseSecond: begin
        out.push_back('{glyph({carry[1:0], b[7:4]}), 1'b0});
        carry     = b[3:0];
        grp_phase = PhaseThird;
        if (last) begin
          out.push_back('{glyph({b[3:0], 2'b00}), 1'b0});
          if (pad_model) out.push_back('{PadChar, 1'b0});
        end
      end
      PhaseThird: begin
        out.push_back('{glyph({carry, b[7:6]}), 1'b0});
        out.push_back('{glyph(b[5:0]), 1'b0});
        carry     = '0;
        grp_phase = PhaseFirst;
      end
      default: begin
        out.push_back('{glyph(b[7:2]), 1'b0});
        carry     = {2'b00, b[1:0]};
        grp_phase = PhaseSecond;
        if (last) begin
          out.push_back('{glyph({b[1:0], 4'b0000}), 1'b0});
          if (pad_model) begin
            out.push_back('{PadChar, 1'b0});
            out.push_back('{PadChar, 1'b0});
          end
        end
      end
    endcase
    // A final byte closes the message and rewinds the group.
    if (last) begin
      out[out.size()-1].lst = 1'b1;
      grp_phase = PhaseFirst;
      carry     = '0;
    end
    if (keep) foreach (out[i]) chars_due.push_back(out[i]);
  endfunction

  // Offer one beat and hold it until the block takes it.
  task automatic send_byte(logic [ByteW-1:0] b, bit last, string want);
    byte_bus.valid     <= 1'b1;
    byte_bus.in_byte   <= b;
    byte_bus.last_byte <= last;
    do @(posedge clk); while (!byte_bus.ready);
    bytes_sent++;
    if (last) msgs_sent++;
    encode_byte(b, last, want.len() == 0);
    // Literal rows carry their own expected text; the shadow still advances.
    for (int i = 0; i < want.len(); i++) begin
      chars_due.push_back('{CharW'(want[i]), (last && i == want.len() - 1)});
    end
  endtask

  task automatic byte_gap(int unsigned n);
    byte_bus.valid   <= 1'b0;
    byte_bus.in_byte <= ByteW'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic apb_write(logic [PAddrW-1:0] addr, logic [PDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((addr >> RegIdxLsb) == PAddrW'(RegPadEnable)) begin
      pad_model = data[0];
      pad_writes++;
    end
    @(posedge clk);
  endtask

  task automatic apb_check_pad();
    logic [PDataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PadAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== PDataW'(pad_model)) begin
      note_mismatch($sformatf("pad_enable read: expected %0h, got %0h", pad_model, rd));
    end
    @(posedge clk);
  endtask

  // Drop valid and let the output drain before touching the register.
  task automatic wait_drained();
    byte_bus.valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_padding(bit en);
    wait_drained();
    apb_write(PadAddr, PDataW'(en));
    apb_check_pad();
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  // Output side: check every beat, stall in short bursts, and hold off long on request.
  initial begin : char_sink
    int unsigned stall_left;
    int unsigned hold_left;
    char_beat_t  want;
    stall_left = 0;
    hold_left  = 0;
    char_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (char_bus.valid && char_bus.ready) begin
        chars_seen++;
        if (chars_due.size() == 0) begin
          note_mismatch($sformatf("unexpected char %02h last %0b",
                                  char_bus.out_char, char_bus.last_char));
        end else begin
          want = chars_due.pop_front();
          if (char_bus.out_char !== want.ch || char_bus.last_char !== want.lst) begin
            note_mismatch($sformatf("char: expected %02h last %0b, got %02h last %0b",
                                    want.ch, want.lst, char_bus.out_char,
                                    char_bus.last_char));
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        char_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        char_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        char_bus.ready <= 1'b0;
      end else begin
        char_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((byte_bus.valid && byte_bus.ready) || (char_bus.valid && char_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("base64_stream_encoder_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n_phase;
    int unsigned len;
    bit          last;
    byte_bus.valid     <= 1'b0;
    byte_bus.in_byte   <= '0;
    byte_bus.last_byte <= 1'b0;
    rst_n = 1'b0;
    grp_phase = PhaseFirst;
    carry     = '0;
    pad_model = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value, then a write to an unmapped index must leave padding alone.
    apb_check_pad();
    apb_write(SpareAddr, '0);
    apb_check_pad();

    // Directed rows: retune padding only when a row asks for another setting.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].pad != pad_model) set_padding(dir_rows[i].pad);
      send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].want);
      if ($urandom_range(0, 3) == 0) byte_gap($urandom_range(1, 4));
    end

    // Random messages, padding flipped per phase; the final phase runs without idling.
    for (int p = 0; p < RandPhases; p++) begin
      set_padding(p[0] == 1'b0 ? 1'b0 : 1'b1);
      idle_on = (p != RandPhases - 1);
      // Park the receiver while bytes keep coming so the queue fills and in_if stalls.
      if (p == 1) hold_req = 1'b1;
      n_phase = 0;
      while (n_phase < ItemsPerPhase) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          last = (k == len - 1);
          send_byte(pick_byte(), last, "");
          n_phase++;
          if (idle_on && $urandom_range(0, 5) == 0) byte_gap($urandom_range(1, 4));
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    foreach (chars_due[i]) begin
      note_mismatch($sformatf("char never arrived: %02h last %0b",
                              chars_due[i].ch, chars_due[i].lst));
    end

    $display("covered %0d bytes in %0d messages, %0d characters checked",
             bytes_sent, msgs_sent, chars_seen);
    $display("padding set %0d times, with one long output hold-off; %0d mismatches",
             pad_writes, err_cnt);
    if (err_cnt == 0) begin
      $display("base64_stream_encoder_unit: match");
    end else begin
      $display("base64_stream_encoder_unit: mismatch");
    end
    $finish;
  end

endmodule
